// File: hw/rtl/rtcma_pkg.sv
package rtcma_pkg;

   localparam int SEC_W  = 6;
   localparam int MIN_W  = 6;
   localparam int HOUR_W = 5;
   localparam int MDAY_W = 5;
   localparam int MON_W  = 4;
   localparam int WDAY_W = 3;
   localparam int YEAR_W = 12;
   localparam int YDAY_W = 9;
   localparam int CMD_W  = 3;
   localparam int MASK_W = 8;

   localparam int FIELDS_W = SEC_W + MIN_W + HOUR_W + MDAY_W + MON_W + WDAY_W
                           + YEAR_W + YDAY_W;
   localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

   localparam logic [SEC_W-1:0]  SEC_MOD    = 6'd60;
   localparam logic [SEC_W-1:0]  SEC_LAST   = 6'd59;
   localparam logic [MIN_W-1:0]  MIN_MOD    = 6'd60;
   localparam logic [MIN_W-1:0]  MIN_LAST   = 6'd59;
   localparam logic [HOUR_W-1:0] HOUR_MOD   = 5'd24;
   localparam logic [MDAY_W-1:0] MDAY_DFLT  = 5'd1;
   localparam logic [MON_W-1:0]  MON_DFLT   = 4'd1;
   localparam logic [WDAY_W-1:0] WDAY_DFLT  = 3'd0;
   localparam logic [YEAR_W-1:0] YEAR_DFLT  = 12'd1900;
   localparam logic [YDAY_W-1:0] YDAY_DFLT  = 9'd1;

   // Alarm mask bit positions
   localparam int MB_SEC  = 0;
   localparam int MB_MIN  = 1;
   localparam int MB_HOUR = 2;
   localparam int MB_MDAY = 3;
   localparam int MB_WDAY = 4;
   localparam int MB_YDAY = 5;
   localparam int MB_MON  = 6;
   localparam int MB_YEAR = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET_TIME   = 3'd0,
      CMD_SET_ALARM  = 3'd1,
      CMD_TICK       = 3'd2,
      CMD_READ       = 3'd3,
      CMD_READ_ALARM = 3'd4
   } cmd_type;

   // Declared highest field first so that sec lands in the lowest bits.
   typedef struct packed {
      logic [YDAY_W-1:0] yday;
      logic [YEAR_W-1:0] year;
      logic [WDAY_W-1:0] wday;
      logic [MON_W-1:0]  mon;
      logic [MDAY_W-1:0] mday;
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  min;
      logic [SEC_W-1:0]  sec;
   } time_fields_type;

   typedef struct packed {
      cmd_type         cmd;
      time_fields_type fields;
   } req_item_type;

   typedef struct packed {
      logic            match;
      time_fields_type fields;
   } rsp_item_type;

   localparam time_fields_type TIME_RESET = '{
      yday: YDAY_DFLT, year: YEAR_DFLT, wday: WDAY_DFLT, mon: MON_DFLT,
      mday: MDAY_DFLT, hour: '0, min: '0, sec: '0
   };

endpackage

// File: hw/rtl/rtc_with_masked_alarm.sv
// Real-time clock register block with a masked alarm compare.
//
// Request channel (req_*): one word per command. req_tuser carries the
// command (set_time, set_alarm, tick, read, read_alarm); req_tdata carries
// the eight time or alarm fields used by set_time and set_alarm.
// Response channel (rsp_*): exactly one word per request, in order. It holds
// the time fields (alarm fields for read_alarm) after the command has taken
// effect, and rsp_tuser carries the alarm match flag.
// Config channel (csr_*): writes the 8-bit alarm mask; always ready. Write it
// only while no request is in flight.
//
// A word passes through the request register and then the response register.
// Throughput is one word per cycle while the receiver keeps rsp_tready high;
// the only loop is the core's state update, which commits as the word advances.
// When the receiver stalls, the response register holds its word and the
// request register can still take one more word before req_tready drops.
// Synchronous reset empties both registers, loads the time with 00:00:00,
// day 1, month 1, weekday 0, year 1900, yday 1, and clears alarm and mask.
module rtc_with_masked_alarm import rtcma_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // from bit 0: sec[6], min[6], hour[5], mday[5], mon[4], wday[3], year[12],
   // yday[9], zero fill
   input  logic [TDATA_W-1:0] req_tdata,
   // from bit 0: cmd[3]
   input  logic [CMD_W-1:0]   req_tuser,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // from bit 0: out_sec[6], out_min[6], out_hour[5], out_mday[5], out_mon[4],
   // out_wday[3], out_year[12], out_yday[9], zero fill
   output logic [TDATA_W-1:0] rsp_tdata,
   // from bit 0: alarm_match[1]
   output logic [0:0]         rsp_tuser,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [MASK_W-1:0]  csr_data
);

   req_item_type req_item;
   req_item_type item;
   logic         item_valid;
   logic         advance;
   rsp_item_type result;
   rsp_item_type rsp_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;

   assign req_item.cmd    = cmd_type'(req_tuser);
   assign req_item.fields = time_fields_type'(req_tdata[FIELDS_W-1:0]);

   // Move the held request into the response register when that has room.
   assign advance = item_valid && (!rsp_valid_ff || rsp_tready);

   rtcma_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // The core commits its state update in the same cycle the word advances.
   rtcma_core u_core (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_valid),
      .csr_mask (csr_data),
      .exec_en  (advance),
      .item     (item),
      .result   (result)
   );

   assign csr_ready = 1'b1;

   // Hold the response until taken; drop valid once it leaves with nothing behind.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(TDATA_W - FIELDS_W){1'b0}}, rsp_item_ff.fields};
   assign rsp_tuser  = rsp_item_ff.match;

endmodule

// File: hw/rtl/rtcma_in_stage.sv
module rtcma_in_stage import rtcma_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   input  logic         advance,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   // Take a new word whenever the held one is empty or moving on.
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: hw/rtl/rtcma_core.sv
module rtcma_core import rtcma_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [MASK_W-1:0] csr_mask,
   input  logic              exec_en,
   input  req_item_type      item,
   output rsp_item_type      result
);

   time_fields_type   time_ff, time_in;
   time_fields_type   alarm_ff, alarm_in;
   logic [MASK_W-1:0] mask_ff;
   time_fields_type   v;
   time_fields_type   clamped;
   logic [MASK_W-1:0] miss;

   assign v = item.fields;

   // Clamp rules for set_time
   always_comb begin
      clamped.sec  = (v.sec >= SEC_MOD) ? v.sec - SEC_MOD : v.sec;
      clamped.min  = (v.min >= MIN_MOD) ? v.min - MIN_MOD : v.min;
      clamped.hour = (v.hour >= HOUR_MOD) ? v.hour - HOUR_MOD : v.hour;
      clamped.mday = (v.mday inside {[5'd2:5'd31]}) ? v.mday : MDAY_DFLT;
      clamped.mon  = (v.mon inside {[4'd2:4'd12]}) ? v.mon : MON_DFLT;
      clamped.wday = (v.wday inside {[3'd2:3'd6]}) ? v.wday : WDAY_DFLT;
      clamped.year = (v.year != '0) ? v.year : YEAR_DFLT;
      clamped.yday = (v.yday inside {[9'd2:9'd365]}) ? v.yday : YDAY_DFLT;
   end

   always_comb begin
      time_in  = time_ff;
      alarm_in = alarm_ff;
      if (exec_en) begin
         case (item.cmd)
            CMD_SET_TIME: begin
               time_in = clamped;
            end
            CMD_SET_ALARM: begin
               alarm_in = v;
            end
            CMD_TICK: begin
               if (time_ff.sec >= SEC_LAST) begin
                  time_in.sec = '0;
                  time_in.min = (time_ff.min >= MIN_LAST) ? '0 : time_ff.min + 1'b1;
               end else begin
                  time_in.sec = time_ff.sec + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Compare against the post-update state.
   always_comb begin
      miss          = '0;
      miss[MB_SEC]  = alarm_in.sec  != time_in.sec;
      miss[MB_MIN]  = alarm_in.min  != time_in.min;
      miss[MB_HOUR] = alarm_in.hour != time_in.hour;
      miss[MB_MDAY] = alarm_in.mday != time_in.mday;
      miss[MB_WDAY] = alarm_in.wday != time_in.wday;
      miss[MB_YDAY] = alarm_in.yday != time_in.yday;
      miss[MB_MON]  = alarm_in.mon  != time_in.mon;
      miss[MB_YEAR] = alarm_in.year != time_in.year;
   end

   assign result.match  = (mask_ff != '0) && ((mask_ff & miss) == '0);
   assign result.fields = (item.cmd == CMD_READ_ALARM) ? alarm_in : time_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff  <= TIME_RESET;
         alarm_ff <= '0;
         mask_ff  <= '0;
      end else begin
         time_ff  <= time_in;
         alarm_ff <= alarm_in;
         if (csr_we) begin
            mask_ff <= csr_mask;
         end
      end
   end

endmodule

// File: bench/rtcma_tb_pkg.sv
package rtcma_tb_pkg;
   import rtcma_pkg::*;

   // Shadow copy of the clock: tracks time, alarm and mask as the block should,
   // and keeps the replies still owed by the block in order.
   class rtc_shadow_clock;
      time_fields_type   now_fields;
      time_fields_type   alarm_regs;
      logic [MASK_W-1:0] mask;
      rsp_item_type      owed_replies[$];
      int                mismatches;
      int                alarm_hits;

      function new();
         now_fields = TIME_RESET;
         alarm_regs = '0;
         mask       = '0;
         mismatches = 0;
         alarm_hits = 0;
      endfunction

      function void load_mask(logic [MASK_W-1:0] value);
         mask = value;
      endfunction

      function int pending();
         return owed_replies.size();
      endfunction

      function logic alarm_equal();
         logic hit;
         hit = (mask != '0);
         if (mask[MB_SEC]  && alarm_regs.sec  != now_fields.sec)  hit = 1'b0;
         if (mask[MB_MIN]  && alarm_regs.min  != now_fields.min)  hit = 1'b0;
         if (mask[MB_HOUR] && alarm_regs.hour != now_fields.hour) hit = 1'b0;
         if (mask[MB_MDAY] && alarm_regs.mday != now_fields.mday) hit = 1'b0;
         if (mask[MB_WDAY] && alarm_regs.wday != now_fields.wday) hit = 1'b0;
         if (mask[MB_YDAY] && alarm_regs.yday != now_fields.yday) hit = 1'b0;
         if (mask[MB_MON]  && alarm_regs.mon  != now_fields.mon)  hit = 1'b0;
         if (mask[MB_YEAR] && alarm_regs.year != now_fields.year) hit = 1'b0;
         return hit;
      endfunction

      // Apply one accepted command and queue the reply it owes.
      function void note_command(logic [CMD_W-1:0] cmd, time_fields_type f);
         rsp_item_type reply;
         case (cmd)
            CMD_SET_TIME: begin
               now_fields.sec  = f.sec % SEC_MOD;
               now_fields.min  = f.min % MIN_MOD;
               now_fields.hour = f.hour % HOUR_MOD;
               now_fields.mday = (f.mday > 1) ? f.mday : MDAY_DFLT;
               now_fields.mon  = (f.mon > 1 && f.mon < 13) ? f.mon : MON_DFLT;
               now_fields.wday = (f.wday > 1 && f.wday < 7) ? f.wday : WDAY_DFLT;
               now_fields.year = (f.year != 0) ? f.year : YEAR_DFLT;
               now_fields.yday = (f.yday > 1 && f.yday < 366) ? f.yday : YDAY_DFLT;
            end
            CMD_SET_ALARM: alarm_regs = f;
            CMD_TICK: begin
               if (now_fields.sec >= SEC_LAST) begin
                  now_fields.sec = '0;
                  now_fields.min = (now_fields.min >= MIN_LAST) ? '0 : now_fields.min + 1'b1;
               end else begin
                  now_fields.sec = now_fields.sec + 1'b1;
               end
            end
            default: ;
         endcase
         reply.fields = (cmd == CMD_READ_ALARM) ? alarm_regs : now_fields;
         reply.match  = alarm_equal();
         owed_replies.push_back(reply);
      endfunction

      function int field_diff(string name, logic [31:0] want_v, logic [31:0] got_v,
                              realtime stamp);
         if (got_v !== want_v) begin
            $display("%0.1f ns: %s mismatch, expected %0d, actual %0d", stamp, name,
                     want_v, got_v);
            return 1;
         end
         return 0;
      endfunction

      // Compare one accepted reply word against the oldest owed reply.
      function void check_reply(logic [TDATA_W-1:0] data, logic [0:0] flag, realtime stamp);
         rsp_item_type    want;
         time_fields_type got;
         int              bad;
         got = data[FIELDS_W-1:0];
         if (owed_replies.size() == 0) begin
            $display("%0.1f ns: reply with none owed, expected nothing, actual %h/%b",
                     stamp, data, flag);
            mismatches++;
            return;
         end
         want = owed_replies.pop_front();
         bad  = 0;
         bad += field_diff("out_sec",  want.fields.sec,  got.sec,  stamp);
         bad += field_diff("out_min",  want.fields.min,  got.min,  stamp);
         bad += field_diff("out_hour", want.fields.hour, got.hour, stamp);
         bad += field_diff("out_mday", want.fields.mday, got.mday, stamp);
         bad += field_diff("out_mon",  want.fields.mon,  got.mon,  stamp);
         bad += field_diff("out_wday", want.fields.wday, got.wday, stamp);
         bad += field_diff("out_year", want.fields.year, got.year, stamp);
         bad += field_diff("out_yday", want.fields.yday, got.yday, stamp);
         bad += field_diff("zero fill", 0, data[TDATA_W-1:FIELDS_W], stamp);
         bad += field_diff("alarm_match", want.match, flag, stamp);
         if (bad != 0) mismatches++;
         if (want.match) alarm_hits++;
      endfunction
   endclass

endpackage

// File: bench/tb_rtc_with_masked_alarm.sv
module tb_rtc_with_masked_alarm;
   timeunit 1ns;
   timeprecision 1ps;

   import rtcma_pkg::*;
   import rtcma_tb_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_WORDS = 175;

   // Every input starts at a known value.
   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]   req_tuser  = CMD_READ;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;
   logic [0:0]         rsp_tuser;
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [MASK_W-1:0]  csr_data   = '0;

   rtc_shadow_clock shadow = new();

   // Idle odds in percent per cycle for each side; changed between phases.
   int send_idle_pct = 12;
   int recv_idle_pct = 78;
   // Raised by the stimulus to make the receiver hold off for a long stretch.
   bit hold_pending  = 1'b0;

   int cmd_count [8];
   int mask_writes   = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   rtc_with_masked_alarm DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Reply sink: check every accepted reply word, then pick tready for the
   // next cycle. A hold request keeps tready low until its hold counter runs out.
   initial begin : reply_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            shadow.check_reply(rsp_tdata, rsp_tuser, $realtime);
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Offer one command word, idling first at random; return once accepted.
   task automatic send_word(logic [CMD_W-1:0] cmd, time_fields_type f);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(TDATA_W - FIELDS_W){1'b0}}, f};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      shadow.note_command(cmd, f);
      cmd_count[cmd]++;
   endtask

   // Drop valid and hold until every owed reply has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
   endtask

   // Write the alarm mask; only called with the block idle.
   task automatic write_mask(logic [MASK_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow.load_mask(value);
      csr_valid <= 1'b0;
      mask_writes++;
   endtask

   function automatic time_fields_type mk(int sec, int min, int hour, int mday, int mon,
                                          int wday, int year, int yday);
      time_fields_type f;
      f.sec  = SEC_W'(sec);
      f.min  = MIN_W'(min);
      f.hour = HOUR_W'(hour);
      f.mday = MDAY_W'(mday);
      f.mon  = MON_W'(mon);
      f.wday = WDAY_W'(wday);
      f.year = YEAR_W'(year);
      f.yday = YDAY_W'(yday);
      return f;
   endfunction

   function automatic time_fields_type raw_fields();
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      return raw[FIELDS_W-1:0];
   endfunction

   function automatic time_fields_type legal_fields();
      return mk($urandom_range(59), $urandom_range(59), $urandom_range(23),
                $urandom_range(31, 1), $urandom_range(12, 1), $urandom_range(6),
                $urandom_range(4095, 1), $urandom_range(365, 1));
   endfunction

   // One random command. Mostly legal time loads, alarms built from the
   // current time so the compare can hit, and runs of ticks; some noise.
   task automatic random_word();
      int              pick;
      int              flavor;
      time_fields_type f;
      logic [CMD_W-1:0] cmd;
      pick   = $urandom_range(99);
      flavor = $urandom_range(3);
      f      = raw_fields();
      if (pick < 12) begin
         cmd = CMD_SET_TIME;
         if (flavor < 2) begin
            f = legal_fields();
         end else if (flavor == 2) begin
            // park near the second and minute wrap
            f     = legal_fields();
            f.sec = SEC_W'($urandom_range(59, 55));
            f.min = MIN_W'($urandom_range(59, 57));
         end
      end else if (pick < 24) begin
         cmd = CMD_SET_ALARM;
         if (flavor < 3) begin
            // alarm at the present time or a few seconds ahead
            f     = shadow.now_fields;
            f.sec = SEC_W'((shadow.now_fields.sec + $urandom_range(3)) % 60);
            if (flavor == 1) f.hour = HOUR_W'($urandom_range(31));
         end
      end else if (pick < 70) begin
         cmd = CMD_TICK;
      end else if (pick < 84) begin
         cmd = CMD_READ;
      end else if (pick < 95) begin
         cmd = CMD_READ_ALARM;
      end else begin
         cmd = CMD_W'($urandom_range(7, 5));
      end
      send_word(cmd, f);
   endtask

   initial begin : stimulus
      logic [MASK_W-1:0] phase_masks [8];
      int                unused_codes;

      phase_masks = '{8'hFE, 8'h00, 8'h01, 8'h80, 8'h00, 8'hFF, 8'h7E, 8'h00};
      phase_masks[4] = MASK_W'($urandom_range(255));
      phase_masks[7] = MASK_W'($urandom_range(255));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed words with the mask still at its reset value.
      send_word(CMD_READ, raw_fields());
      send_word(CMD_READ_ALARM, raw_fields());
      send_word(CMD_SET_TIME, mk(63, 63, 31, 31, 15, 7, 4095, 511));
      send_word(CMD_SET_TIME, mk(0, 0, 0, 0, 0, 0, 0, 0));
      send_word(CMD_SET_TIME, mk(60, 60, 24, 1, 13, 1, 0, 366));
      send_word(CMD_SET_TIME, mk(59, 59, 23, 31, 12, 6, 1, 365));
      // seconds and minutes both wrap
      send_word(CMD_TICK, raw_fields());
      send_word(CMD_SET_TIME, mk(2, 2, 2, 2, 2, 2, 2, 2));
      send_word(CMD_SET_TIME, mk(58, 7, 5, 17, 6, 3, 2024, 200));
      send_word(CMD_TICK, raw_fields());
      // seconds wrap, minutes advance by one
      send_word(CMD_TICK, raw_fields());
      send_word(CMD_SET_ALARM, mk(63, 63, 31, 31, 15, 7, 4095, 511));
      send_word(CMD_READ_ALARM, raw_fields());
      // unused codes behave as read
      send_word(3'd5, raw_fields());
      send_word(3'd6, raw_fields());
      send_word(3'd7, raw_fields());
      wait_drained();

      // Full mask: an alarm at the present time hits until the next tick.
      write_mask(8'hFF);
      send_word(CMD_SET_ALARM, shadow.now_fields);
      send_word(CMD_READ, raw_fields());
      send_word(CMD_TICK, raw_fields());
      send_word(CMD_READ_ALARM, raw_fields());
      wait_drained();

      // Minutes only: the hit survives ticks within the minute.
      write_mask(8'h02);
      send_word(CMD_SET_ALARM, shadow.now_fields);
      send_word(CMD_TICK, raw_fields());
      send_word(CMD_SET_ALARM, mk(0, 0, 0, 0, 0, 0, 0, 0));
      wait_drained();

      // Random phases, each under its own mask and idle pattern.
      for (int phase = 0; phase < 8; phase++) begin
         if (phase < 3) begin
            send_idle_pct = 12;
            recv_idle_pct = 78;
         end else if (phase < 6) begin
            send_idle_pct = 78;
            recv_idle_pct = 12;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_mask(phase_masks[phase]);
         if (phase == 6) begin
            // receiver holds off while the sender keeps offering: fill up
            hold_pending = 1'b1;
            repeat (30) random_word();
         end
         repeat (PHASE_WORDS) random_word();
         wait_drained();
      end

      // Let any stray reply show up before the verdict.
      repeat (8) @(posedge clock);

      unused_codes = cmd_count[5] + cmd_count[6] + cmd_count[7];
      $display("covered set_time %0d, set_alarm %0d, tick %0d, read %0d, read_alarm %0d, %0d unused",
               cmd_count[CMD_SET_TIME], cmd_count[CMD_SET_ALARM], cmd_count[CMD_TICK],
               cmd_count[CMD_READ], cmd_count[CMD_READ_ALARM], unused_codes);
      $display("%0d mask writes, %0d alarm hits, %0d bad replies, %0d left owed",
               mask_writes, shadow.alarm_hits, shadow.mismatches, shadow.pending());
      if (shadow.mismatches == 0 && shadow.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #1_000_000;
      $display("timeout with %0d replies still owed", shadow.pending());
      $display("status: fail");
      $finish;
   end

endmodule
